@@ sv/slmd_pkg.sv @@
package slmd_pkg;

    // Default frame limits handed to the top level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CH_W        = 8;
    localparam int RGB_W       = 3 * CH_W;
    localparam int POS_W       = 10;
    localparam int OUT_INDEX_W = 20;
    localparam int PROD_W      = 2 * CH_W;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = CFG_W'(1024);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Request operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [RGB_W-1:0] t_rgb;

    // Saturation as an exact fraction num/den
    typedef struct packed {
        logic [CH_W-1:0] num;
        logic [CH_W-1:0] den;
    } t_sat;

    typedef struct packed {
        logic [POS_W-1:0] pixel_row;
        logic [POS_W-1:0] pixel_col;
        t_rgb             rgb;
        logic             is_local_max;
        logic             frame_last;
    } t_dec;

    function automatic t_sat saturation(input t_rgb px);
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        t_sat            s;
        r  = px[RGB_W-1 -: CH_W];
        g  = px[2*CH_W-1 -: CH_W];
        b  = px[CH_W-1:0];
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (mx == '0) begin
            s.num = '0;
            s.den = CH_W'(1);
        end else begin
            s.num = mx - mn;
            s.den = mx;
        end
        return s;
    endfunction

endpackage

@@ sv/slmd_in_if.sv @@
interface slmd_in_if import slmd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            operation;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output operation, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input operation, input red, input green, input blue,
                    output ready);
endinterface

@@ sv/slmd_out_if.sv @@
interface slmd_out_if import slmd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pixel_row;
    logic [POS_W-1:0] pixel_col;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             is_local_max;
    logic             frame_last;

    modport source (output valid, output pixel_row, output pixel_col, output out_red,
                    output out_green, output out_blue, output is_local_max,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, input out_red,
                    input out_green, input out_blue, input is_local_max,
                    input frame_last, output ready);
endinterface

@@ sv/saturation_local_max_detector.sv @@
// Strict 3x3 local maximum of HSV saturation over a raster RGB stream. Send the
// pixels of a frame in raster order, then frame_width+1 flush requests; each
// decision appears frame_width+1 requests after its pixel and carries the pixel's
// position and colour. Saturations are compared exactly as fractions (max-min)/max,
// and neighbours outside the frame are skipped. One request is taken every clock
// while ready is high: two line buffers (one synchronous RAM each, MAX_WIDTH
// entries) are read when a request is taken and written back the cycle after, with
// forwarding when two consecutive requests hit the same column. A decision passes
// the stage 1, stage 2 and stage 3 registers before it is written into the output
// queue, and the 8-entry queue lets ready stay high while the consumer stalls,
// until more than four decisions are waiting. After a write to frame_width, ready
// stays low while a one-bit-per-cycle divider re-derives the row and column of the
// next decision. Line buffers and window have no reset and no clearing pass;
// configuration must be written while idle, which the block does not enforce.
module saturation_local_max_detector import slmd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    slmd_in_if.sink              i_pix,
    slmd_out_if.source           o_dec
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int IRW       = $clog2(MAX_HEIGHT);
    localparam int FCW       = $clog2(MAX_WIDTH + 2);
    localparam int CNT_W     = FIFO_PTR_W + 1;
    localparam int DIV_CNT_W = $clog2(OUT_INDEX_W);

    // Configuration and clamped frame size
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;

    // Position counters
    logic [IRW-1:0]         r_in_row,    n_in_row;
    logic [CW-1:0]          r_in_col,    n_in_col;
    logic [FCW-1:0]         r_fc,        n_fc;
    logic [OUT_INDEX_W-1:0] r_out_index, n_out_index;
    logic [OUT_INDEX_W-1:0] r_out_row,   n_out_row;
    logic [CW-1:0]          r_out_col,   n_out_col;

    // Divider for row/column of the output index
    logic                   r_div_busy;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [OUT_INDEX_W-1:0] r_div_dq,  n_div_dq;
    logic [CFG_W-1:0]       r_div_rem, n_div_rem;
    logic [CFG_W:0]         div_t;
    logic                   div_ge;
    logic                   div_done;

    // Request decode
    logic       in_acc;
    logic       eff;
    logic       emit;
    logic       last_flush;
    logic       col_wrap;
    logic       last_pixel;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic [8:0] nb_ok;
    t_rgb       in_px;

    // Stage 1: line buffer data
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic             r_s1_fwd;
    logic [CW-1:0]    r_s1_col;
    t_rgb             r_s1_px;
    logic [POS_W-1:0] r_s1_row_o;
    logic [POS_W-1:0] r_s1_col_o;
    logic [8:0]       r_s1_ok;

    t_rgb mem_mid [MAX_WIDTH];
    t_rgb mem_top [MAX_WIDTH];
    t_rgb r_rd_mid;
    t_rgb r_rd_top;
    t_rgb r_wr_mid;
    t_rgb r_wr_top;
    t_rgb mid_eff;
    t_rgb top_eff;

    // Window: saturation of all nine, colour of the middle row centre and right
    t_sat r_win_sat [9];
    t_rgb r_win_rgb_c;
    t_rgb r_win_rgb_r;

    // Stage 2
    logic             r_s2_emit;
    logic             r_s2_last;
    logic [POS_W-1:0] r_s2_row_o;
    logic [POS_W-1:0] r_s2_col_o;
    logic [8:0]       r_s2_ok;

    // Stage 3: cross products
    logic              r_s3_emit;
    logic              r_s3_last;
    logic [POS_W-1:0]  r_s3_row_o;
    logic [POS_W-1:0]  r_s3_col_o;
    t_rgb              r_s3_rgb;
    logic [8:0]        r_s3_ok;
    logic [PROD_W-1:0] r_s3_pn [9];
    logic [PROD_W-1:0] r_s3_pc [9];
    logic [8:0]        beat;
    logic              is_max;

    // Output queue
    t_dec                  r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0]      r_fcount;
    logic                  fifo_pop;
    t_dec                  fifo_head;

    // ------------------------------------------------------------------
    // Frame size: zero counts as one, oversize as the limit
    // ------------------------------------------------------------------
    always_comb begin
        if (r_frame_width == '0) begin
            w = CFG_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w = CFG_W'(MAX_WIDTH);
        end else begin
            w = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h = CFG_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h = CFG_W'(MAX_HEIGHT);
        end else begin
            h = r_frame_height;
        end
    end

    // ------------------------------------------------------------------
    // Request handshake and decode
    // ------------------------------------------------------------------
    // Hold off while the divider runs, during a configuration write, and
    // when the queue could not absorb everything already in flight.
    assign i_pix.ready = !r_div_busy && !i_cfg_we
                         && (r_fcount <= CNT_W'(FIFO_DEPTH - 4));
    assign in_acc = i_pix.valid && i_pix.ready;

    // Drop pixels while flushing and flushes while taking pixels
    assign eff = in_acc && (((i_pix.operation == OP_PIXEL) && (r_fc == '0))
                         || ((i_pix.operation == OP_FLUSH) && (r_fc != '0)));

    assign in_px = (i_pix.operation == OP_PIXEL) ? {i_pix.red, i_pix.green, i_pix.blue}
                                                 : '0;

    always_comb begin
        if (i_pix.operation == OP_PIXEL) begin
            emit = (r_in_row >= IRW'(2)) || ((r_in_row == IRW'(1)) && (r_in_col != '0));
        end else begin
            // A one-row frame owes nothing on its first flush
            emit = !((h == CFG_W'(1)) && (32'(r_fc) >= 32'(w) + 1));
        end
    end

    assign last_flush = (i_pix.operation == OP_FLUSH) && (r_fc == FCW'(1));
    assign col_wrap   = (32'(r_in_col) + 1) >= 32'(w);
    assign last_pixel = ((32'(r_in_row) + 1) >= 32'(h)) && col_wrap;

    // In-frame tests for the neighbours of the decided pixel
    assign row_ok[0] = (r_out_row != '0) && ((32'(r_out_row) - 1) < 32'(h));
    assign row_ok[1] = 32'(r_out_row) < 32'(h);
    assign row_ok[2] = (32'(r_out_row) + 1) < 32'(h);
    assign col_ok[0] = (r_out_col != '0) && ((32'(r_out_col) - 1) < 32'(w));
    assign col_ok[1] = 32'(r_out_col) < 32'(w);
    assign col_ok[2] = (32'(r_out_col) + 1) < 32'(w);

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            nb_ok[k] = row_ok[k / 3] && col_ok[k % 3];
        end
        nb_ok[4] = 1'b0;
    end

    // ------------------------------------------------------------------
    // Counters
    // ------------------------------------------------------------------
    always_comb begin
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_fc        = r_fc;
        n_out_index = r_out_index;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        if (eff) begin
            if (emit) begin
                if (r_out_index == '1) begin
                    n_out_index = '0;
                    n_out_row   = '0;
                    n_out_col   = '0;
                end else begin
                    n_out_index = r_out_index + 1'b1;
                    if ((32'(r_out_col) + 1) >= 32'(w)) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                end
            end
            if (i_pix.operation == OP_PIXEL) begin
                if (col_wrap) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
                if (last_pixel) begin
                    n_in_row = '0;
                    n_in_col = '0;
                    n_fc     = FCW'(32'(w) + 1);
                end
            end else begin
                n_in_col = col_wrap ? '0 : r_in_col + 1'b1;
                n_fc     = r_fc - 1'b1;
                // End of flush: return every counter to the frame start
                if (r_fc == FCW'(1)) begin
                    n_in_row    = '0;
                    n_in_col    = '0;
                    n_out_index = '0;
                    n_out_row   = '0;
                    n_out_col   = '0;
                end
            end
        end
        if (div_done) begin
            n_out_row = n_div_dq;
            n_out_col = CW'(n_div_rem);
        end
    end

    // Restoring division, one quotient bit a cycle
    assign div_t     = {r_div_rem, r_div_dq[OUT_INDEX_W-1]};
    assign div_ge    = div_t >= {1'b0, w};
    assign n_div_rem = div_ge ? CFG_W'(div_t - {1'b0, w}) : CFG_W'(div_t);
    assign n_div_dq  = {r_div_dq[OUT_INDEX_W-2:0], div_ge};
    assign div_done  = r_div_busy && (r_div_cnt == DIV_CNT_W'(OUT_INDEX_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_SIZE_RESET;
            r_frame_height <= FRAME_SIZE_RESET;
            r_in_row       <= '0;
            r_in_col       <= '0;
            r_fc           <= '0;
            r_out_index    <= '0;
            r_out_row      <= '0;
            r_out_col      <= '0;
            r_div_busy     <= 1'b0;
            r_div_cnt      <= '0;
        end else begin
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_fc        <= n_fc;
            r_out_index <= n_out_index;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            if (r_div_busy) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (div_done) r_div_busy <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data;
                        // Re-derive row and column under the new width
                        r_div_busy    <= 1'b1;
                        r_div_cnt     <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we && (i_cfg_index == CFG_FRAME_WIDTH)) begin
            r_div_dq  <= r_out_index;
            r_div_rem <= '0;
        end else if (r_div_busy) begin
            r_div_dq  <= n_div_dq;
            r_div_rem <= n_div_rem;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: request registered, line buffers read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= eff;
            r_s1_emit  <= eff && emit;
            // The write of the request ahead lands in this same cycle
            r_s1_fwd   <= eff && r_s1_valid && (r_s1_col == r_in_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (eff) begin
            r_s1_col   <= r_in_col;
            r_s1_px    <= in_px;
            r_s1_last  <= last_flush;
            r_s1_row_o <= POS_W'(r_out_row);
            r_s1_col_o <= POS_W'(r_out_col);
            r_s1_ok    <= nb_ok;
        end
    end

    // Line buffers: read every cycle at the next column, written back in the following cycle
    always_ff @(posedge i_clk) begin
        r_rd_mid <= mem_mid[r_in_col];
        r_rd_top <= mem_top[r_in_col];
        if (r_s1_valid) begin
            mem_mid[r_s1_col] <= r_s1_px;
            mem_top[r_s1_col] <= mid_eff;
        end
    end

    assign mid_eff = r_s1_fwd ? r_wr_mid : r_rd_mid;
    assign top_eff = r_s1_fwd ? r_wr_top : r_rd_top;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_wr_mid <= r_s1_px;
            r_wr_top <= mid_eff;
        end
    end

    // Advance the window by one column
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win_sat[k*3]     <= r_win_sat[k*3 + 1];
                r_win_sat[k*3 + 1] <= r_win_sat[k*3 + 2];
            end
            r_win_sat[2] <= saturation(top_eff);
            r_win_sat[5] <= saturation(mid_eff);
            r_win_sat[8] <= saturation(r_s1_px);
            r_win_rgb_c  <= r_win_rgb_r;
            r_win_rgb_r  <= mid_eff;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: window ready, cross-multiply
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_emit <= 1'b0;
            r_s3_emit <= 1'b0;
        end else begin
            r_s2_emit <= r_s1_emit;
            r_s3_emit <= r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last  <= r_s1_last;
        r_s2_row_o <= r_s1_row_o;
        r_s2_col_o <= r_s1_col_o;
        r_s2_ok    <= r_s1_ok;

        r_s3_last  <= r_s2_last;
        r_s3_row_o <= r_s2_row_o;
        r_s3_col_o <= r_s2_col_o;
        r_s3_ok    <= r_s2_ok;
        r_s3_rgb   <= r_win_rgb_c;
        for (int k = 0; k < 9; k++) begin
            r_s3_pn[k] <= PROD_W'(r_win_sat[k].num) * PROD_W'(r_win_sat[4].den);
            r_s3_pc[k] <= PROD_W'(r_win_sat[4].num) * PROD_W'(r_win_sat[k].den);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compare, push the decision
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            beat[k] = !r_s3_ok[k] || (r_s3_pc[k] > r_s3_pn[k]);
        end
    end

    assign is_max = &beat;

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    assign fifo_pop  = o_dec.valid && o_dec.ready;
    assign fifo_head = r_fifo[r_rptr];

    always_ff @(posedge i_clk) begin
        if (r_s3_emit) begin
            r_fifo[r_wptr] <= '{pixel_row:    r_s3_row_o,
                                pixel_col:    r_s3_col_o,
                                rgb:          r_s3_rgb,
                                is_local_max: is_max,
                                frame_last:   r_s3_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_fcount <= '0;
        end else begin
            if (r_s3_emit) r_wptr <= r_wptr + 1'b1;
            if (fifo_pop)  r_rptr <= r_rptr + 1'b1;
            if (r_s3_emit && !fifo_pop) begin
                r_fcount <= r_fcount + 1'b1;
            end else if (!r_s3_emit && fifo_pop) begin
                r_fcount <= r_fcount - 1'b1;
            end
        end
    end

    assign o_dec.valid        = (r_fcount != '0);
    assign o_dec.pixel_row    = fifo_head.pixel_row;
    assign o_dec.pixel_col    = fifo_head.pixel_col;
    assign o_dec.out_red      = fifo_head.rgb[RGB_W-1 -: CH_W];
    assign o_dec.out_green    = fifo_head.rgb[2*CH_W-1 -: CH_W];
    assign o_dec.out_blue     = fifo_head.rgb[CH_W-1:0];
    assign o_dec.is_local_max = fifo_head.is_local_max;
    assign o_dec.frame_last   = fifo_head.frame_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_emit && !fifo_pop) |-> (r_fcount < CNT_W'(FIFO_DEPTH)))
        else $error("decision pushed into a full output queue");

    a_div_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !i_pix.ready)
        else $error("request taken while the row/column divider runs");

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid)
        else $error("line buffer forwarding without an item in stage 1");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_div_busy |-> (32'(r_out_col) < 32'(w)))
        else $error("output column outside the frame width");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import slmd_pkg::*;

    // The block is built with its default frame limits, so the predictor
    // keeps line buffers of the same length.
    localparam int LINE_LEN     = DEF_MAX_WIDTH;
    localparam int ROWS_MAX     = DEF_MAX_HEIGHT;
    // Requests spent on random frames; the tall out-of-range frame at the
    // end brings the run to about 1600.
    localparam int RANDOM_ITEMS = 560;
    // Long consumer stall used to back the block up into its input.
    localparam int HOLD_CYCLES  = 300;
    // Quiet cycles after the last decision before a register write or the
    // final verdict.
    localparam int SETTLE       = 12;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_CAP    = 20;

    // Colours whose saturations tie with each other (1, 1, 3/4, 3/4).
    localparam t_rgb TIE_PALETTE [4] = '{24'hFF0000, 24'h804000, 24'h804020, 24'hC86432};

    // Expected decisions, worked out from every accepted request.
    class decision_board;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        t_rgb             line_mem [2*LINE_LEN];
        t_rgb             window [9];
        int unsigned      next_row;
        int unsigned      next_col;
        int unsigned      dec_index;
        int unsigned      flushes_owed;
        t_dec             pending_decisions [$];
        int unsigned      mismatches;

        function new();
            width_reg    = FRAME_SIZE_RESET;
            height_reg   = FRAME_SIZE_RESET;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (window[i]) window[i] = '0;
            next_row     = 0;
            next_col     = 0;
            dec_index    = 0;
            flushes_owed = 0;
            mismatches   = 0;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_FRAME_WIDTH) width_reg = val;
            else if (idx == CFG_FRAME_HEIGHT) height_reg = val;
        endfunction

        static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        // Saturation as the exact fraction (max - min) / max, black as 0/1.
        static function void chroma_ratio(t_rgb px, output int unsigned num,
                                          output int unsigned den);
            int unsigned r, g, b, hi, lo;
            r  = px[RGB_W-1 -: CH_W];
            g  = px[2*CH_W-1 -: CH_W];
            b  = px[CH_W-1:0];
            hi = (r > g) ? r : g;
            hi = (b > hi) ? b : hi;
            lo = (r < g) ? r : g;
            lo = (b < lo) ? b : lo;
            num = (hi == 0) ? 0 : hi - lo;
            den = (hi == 0) ? 1 : hi;
        endfunction

        function void note_request(logic op, t_rgb colour);
            int unsigned w, h, col, r, c, cn, cd, nn, nd;
            int          rr, cc, dr, dc, k;
            t_rgb        px, top, mid;
            bit          emit, last_flush, peak, frame_done;
            t_dec        d;
            w = clamp_dim(width_reg, LINE_LEN);
            h = clamp_dim(height_reg, ROWS_MAX);
            // Drop pixels while flushing and flushes while taking pixels.
            if (op == OP_PIXEL && flushes_owed != 0) return;
            if (op == OP_FLUSH && flushes_owed == 0) return;
            px  = (op == OP_PIXEL) ? colour : '0;
            col = (next_col >= LINE_LEN) ? LINE_LEN - 1 : next_col;
            top = line_mem[LINE_LEN + col];
            mid = line_mem[col];
            line_mem[LINE_LEN + col] = mid;
            line_mem[col] = px;
            for (k = 0; k < 3; k++) begin
                window[3*k]   = window[3*k+1];
                window[3*k+1] = window[3*k+2];
            end
            window[2] = top;
            window[5] = mid;
            window[8] = px;
            if (op == OP_PIXEL) begin
                emit = next_row >= 2 || (next_row == 1 && next_col >= 1);
            end else begin
                emit = !(h == 1 && flushes_owed >= w + 1);
            end
            last_flush = (op == OP_FLUSH) && (flushes_owed == 1);
            if (emit) begin
                r = dec_index / w;
                c = dec_index % w;
                chroma_ratio(window[4], cn, cd);
                peak = 1'b1;
                for (dr = -1; dr <= 1; dr++) begin
                    for (dc = -1; dc <= 1; dc++) begin
                        rr = int'(r) + dr;
                        cc = int'(c) + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < int'(h)
                            && cc >= 0 && cc < int'(w)) begin
                            chroma_ratio(window[(dr+1)*3 + dc + 1], nn, nd);
                            if (nn * cd >= cn * nd) peak = 1'b0;
                        end
                    end
                end
                d.pixel_row    = POS_W'(r);
                d.pixel_col    = POS_W'(c);
                d.rgb          = window[4];
                d.is_local_max = peak;
                d.frame_last   = last_flush;
                pending_decisions.insert(pending_decisions.size(), d);
                dec_index = (dec_index + 1) & ((1 << OUT_INDEX_W) - 1);
            end
            if (op == OP_PIXEL) begin
                frame_done = (next_row + 1 >= h) && (next_col + 1 >= w);
                next_col++;
                if (next_col >= w) begin
                    next_col = 0;
                    next_row = (next_row + 1) & ((1 << POS_W) - 1);
                end
                if (frame_done) begin
                    next_row     = 0;
                    next_col     = 0;
                    flushes_owed = w + 1;
                end
            end else begin
                next_col++;
                if (next_col >= w) next_col = 0;
                flushes_owed--;
                if (flushes_owed == 0) begin
                    next_row  = 0;
                    next_col  = 0;
                    dec_index = 0;
                end
            end
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            if (mismatches < PRINT_CAP)
                $display("mismatch %s: got %0d, want %0d", what, got, want);
            mismatches++;
        endtask

        task check_decision(t_dec got);
            t_dec want;
            if (pending_decisions.size() == 0) begin
                report("unexpected decision at row", got.pixel_row, 0);
                return;
            end
            want = pending_decisions.pop_front();
            if (got.pixel_row !== want.pixel_row)
                report("pixel_row", got.pixel_row, want.pixel_row);
            if (got.pixel_col !== want.pixel_col)
                report("pixel_col", got.pixel_col, want.pixel_col);
            if (got.rgb[RGB_W-1 -: CH_W] !== want.rgb[RGB_W-1 -: CH_W])
                report("out_red", got.rgb[RGB_W-1 -: CH_W], want.rgb[RGB_W-1 -: CH_W]);
            if (got.rgb[2*CH_W-1 -: CH_W] !== want.rgb[2*CH_W-1 -: CH_W])
                report("out_green", got.rgb[2*CH_W-1 -: CH_W], want.rgb[2*CH_W-1 -: CH_W]);
            if (got.rgb[CH_W-1:0] !== want.rgb[CH_W-1:0])
                report("out_blue", got.rgb[CH_W-1:0], want.rgb[CH_W-1:0]);
            if (got.is_local_max !== want.is_local_max)
                report("is_local_max", got.is_local_max, want.is_local_max);
            if (got.frame_last !== want.frame_last)
                report("frame_last", got.frame_last, want.frame_last);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    slmd_in_if  pix ();
    slmd_out_if dec ();

    saturation_local_max_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix),
        .o_dec       (dec)
    );

    decision_board board = new();
    int unsigned   src_idle_pct;
    int unsigned   sink_idle_pct;
    int unsigned   items_sent = 0;
    bit            hold_wanted = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly ordinary colours, with a share of greys, colours with a zero
    // channel, saturations that tie, channels at the extremes and near-black.
    function automatic t_rgb random_pixel();
        t_rgb px;
        logic [CH_W-1:0] v;
        px = t_rgb'($urandom);
        case ($urandom_range(9))
            0, 1, 2, 3: ;
            4: begin
                v  = CH_W'($urandom);
                px = {v, v, v};
            end
            5: px[CH_W*$urandom_range(2) +: CH_W] = '0;
            6: px = TIE_PALETTE[$urandom_range(3)];
            7: px = {($urandom_range(1) ? 8'hFF : 8'h00), ($urandom_range(1) ? 8'hFF : 8'h00),
                     ($urandom_range(1) ? 8'hFF : 8'h00)};
            default: px = px & 24'h030303;
        endcase
        return px;
    endfunction

    // Offer one request, idling first at the sender's rate. Enter and leave
    // at a falling edge; valid stays high on return so requests can run
    // back to back.
    task automatic send_request(logic op, t_rgb colour);
        while ($urandom_range(99) < src_idle_pct) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.operation <= op;
        pix.red       <= colour[RGB_W-1 -: CH_W];
        pix.green     <= colour[2*CH_W-1 -: CH_W];
        pix.blue      <= colour[CH_W-1:0];
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        board.note_request(op, colour);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected decision is out, then give
    // the pipeline time to empty of requests that produce nothing.
    task automatic settle_idle();
        pix.valid <= 1'b0;
        while (board.pending_decisions.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_size(idx, val);
        @(negedge i_clk);
    endtask

    task automatic apply_size(int unsigned w, int unsigned h);
        settle_idle();
        write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
    endtask

    // One whole frame plus its flush, with the odd stray request mixed in
    // that the block has to ignore.
    task automatic send_frame(int unsigned w, int unsigned h);
        int unsigned n;
        for (n = 0; n < w * h; n++) begin
            if ($urandom_range(99) < 4) send_request(OP_FLUSH, t_rgb'($urandom));
            send_request(OP_PIXEL, random_pixel());
        end
        for (n = 0; n <= w; n++) begin
            if ($urandom_range(99) < 4) send_request(OP_PIXEL, random_pixel());
            send_request(OP_FLUSH, t_rgb'($urandom));
        end
        items_sent += w * h + w + 1;
    endtask

    // Random frames, mostly narrow and short; keep the last size now and
    // then so frames also follow each other without a pause.
    task automatic run_random(int unsigned target);
        int unsigned w, h;
        w = 0;
        h = 0;
        while (items_sent < target) begin
            if (w == 0 || $urandom_range(9) < 7) begin
                case ($urandom_range(9))
                    0, 1, 2: w = $urandom_range(1, 4);
                    9:       w = $urandom_range(17, 40);
                    default: w = $urandom_range(5, 16);
                endcase
                h = ($urandom_range(9) < 4) ? $urandom_range(1, 3) : $urandom_range(4, 8);
                apply_size(w, h);
            end
            send_frame(w, h);
        end
    endtask

    // Consumer: idle at its own rate, or hold ready low for a long stretch
    // when asked, and check every decision taken.
    initial begin
        int unsigned hold_left;
        t_dec        got;
        hold_left = 0;
        dec.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_wanted) begin
                hold_left   = HOLD_CYCLES;
                hold_wanted = 1'b0;
            end
            if (hold_left != 0) begin
                dec.ready <= 1'b0;
                hold_left--;
            end else begin
                dec.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
            @(posedge i_clk);
            if (dec.valid && dec.ready) begin
                got.pixel_row    = dec.pixel_row;
                got.pixel_col    = dec.pixel_col;
                got.rgb          = {dec.out_red, dec.out_green, dec.out_blue};
                got.is_local_max = dec.is_local_max;
                got.frame_last   = dec.frame_last;
                board.check_decision(got);
            end
        end
    end

    // Watchdog: end the run if neither side moves for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix.valid && pix.ready) || (dec.valid && dec.ready)) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        // Hand-picked 3x3 frame: pure colours, black, white, a tie between
        // the top-left corner and the pixel below it, and a clear maximum
        // in the bottom-right corner.
        t_rgb corner_grid [9];
        corner_grid = '{24'hFF0000, 24'h000000, 24'hFFFFFF,
                        24'h804000, 24'hC86432, 24'h5A3C1E,
                        24'h010000, 24'h0A141E, 24'h0000FF};

        pix.valid     = 1'b0;
        pix.operation = OP_PIXEL;
        pix.red       = '0;
        pix.green     = '0;
        pix.blue      = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_FRAME_WIDTH;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        src_idle_pct  = 10;
        sink_idle_pct = 61;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a stray flush before the frame, the 3x3 frame, a stray
        // pixel in the middle of its flush.
        apply_size(3, 3);
        send_request(OP_FLUSH, 24'hFFFFFF);
        foreach (corner_grid[i]) send_request(OP_PIXEL, corner_grid[i]);
        send_request(OP_FLUSH, 24'h000000);
        send_request(OP_FLUSH, 24'hA5A5A5);
        send_request(OP_PIXEL, 24'h00FF00);
        send_request(OP_FLUSH, 24'h5A5A5A);
        send_request(OP_FLUSH, 24'hFFFFFF);

        // Single pixel frame: the first flush yields nothing.
        apply_size(1, 1);
        send_request(OP_PIXEL, 24'hFF00FF);
        send_request(OP_FLUSH, 24'h000000);
        send_request(OP_FLUSH, 24'h000000);

        // Random frames under three idling regimes.
        run_random(RANDOM_ITEMS / 3);
        src_idle_pct  = 61;
        sink_idle_pct = 10;
        run_random(2 * RANDOM_ITEMS / 3);
        src_idle_pct  = 0;
        sink_idle_pct = 0;

        // Hold the consumer off while a full frame streams in, so the output
        // queue fills and the block has to push back on its input.
        apply_size(16, 8);
        hold_wanted = 1'b1;
        send_frame(16, 8);
        run_random(RANDOM_ITEMS);

        // Out-of-range sizes: zero width reads as one and an oversized height
        // as the limit; then a zero height reads as one.
        apply_size(0, 2047);
        send_frame(1, ROWS_MAX);
        apply_size(3, 0);
        send_frame(3, 1);

        settle_idle();
        if (board.mismatches == 0 && board.pending_decisions.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/slmd_pkg.sv
sv/slmd_in_if.sv
sv/slmd_out_if.sv
sv/saturation_local_max_detector.sv
tb/sv/testbench.sv
